// ===== design/bcgf_pkg.sv =====
package bcgf_pkg;

    // Frame geometry
    localparam int IMG_WIDTH  = 160;
    localparam int IMG_HEIGHT = 120;

    // Fill rule constants
    localparam int FILL_RESET    = 6;
    localparam int BORDER_MARGIN = 5;
    localparam int CROSS_RADIUS  = 4;

    // Window geometry: nine line cells, nine taps exposed per cell
    localparam int WIN_ROWS = 2 * CROSS_RADIUS + 1;
    localparam int TAP_SPAN = 2 * CROSS_RADIUS + 1;
    localparam int CENTER   = CROSS_RADIUS;

    // Stream timing
    localparam int OUT_LAG      = CROSS_RADIUS * IMG_WIDTH + CROSS_RADIUS;
    localparam int FRAME_PIXELS = IMG_WIDTH * IMG_HEIGHT;

    // Field widths
    localparam int THRESH_W = 5;
    localparam int SCORE_W  = 5;
    localparam int COUNT_W  = $clog2(FRAME_PIXELS + 1);
    localparam int ROW_W    = $clog2(IMG_HEIGHT);
    localparam int COL_W    = $clog2(IMG_WIDTH);

    // Action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef logic [TAP_SPAN-1:0] tap_row_t;
    typedef tap_row_t [WIN_ROWS-1:0] tap_grid_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } win_pos_t;

    typedef struct packed {
        logic pixel;
        logic eof;
    } result_t;

endpackage

// ===== design/bcgf_cell.sv =====
module bcgf_cell (
    input  logic               clk,
    input  logic               shift_en,
    input  logic               din,
    output bcgf_pkg::tap_row_t taps,
    output logic               dout
);
    import bcgf_pkg::*;

    // One image line of the window, newest pixel in bit 0
    logic [IMG_WIDTH-1:0] line_reg;
    logic [IMG_WIDTH-1:0] line_next;

    // Advance the line by one pixel on each shift
    always_comb
    begin
        line_next = line_reg;
        if (shift_en)
        begin
            line_next = {line_reg[IMG_WIDTH-2:0], din};
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

    // Taps as they stand after the shift: incoming pixel first
    assign taps = {line_reg[TAP_SPAN-2:0], din};
    assign dout = line_reg[IMG_WIDTH-1];

endmodule

// ===== design/bcgf_decide.sv =====
module bcgf_decide (
    input  bcgf_pkg::tap_grid_t             taps,
    input  bcgf_pkg::win_pos_t              pos,
    input  logic [bcgf_pkg::THRESH_W-1:0]   threshold,
    output logic                            pixel
);
    import bcgf_pkg::*;

    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    logic               seed;
    logic [2:0]         group_sum [CROSS_RADIUS];
    logic [SCORE_W-1:0] score;
    logic               center;

    // Interior test for the three neighbor rows and columns
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            row_ok[d] = ({1'b0, pos.row} >= (ROW_W+1)'(BORDER_MARGIN - (d - 1))) &&
                        ({1'b0, pos.row} <=
                         (ROW_W+1)'(IMG_HEIGHT - 1 - BORDER_MARGIN - (d - 1)));
            col_ok[d] = ({1'b0, pos.col} >= (COL_W+1)'(BORDER_MARGIN - (d - 1))) &&
                        ({1'b0, pos.col} <=
                         (COL_W+1)'(IMG_WIDTH - 1 - BORDER_MARGIN - (d - 1)));
        end
    end

    // Look for a set neighbor well inside the frame
    always_comb
    begin
        seed = 1'b0;
        for (int dy = 0; dy < 3; dy++)
        begin
            for (int dx = 0; dx < 3; dx++)
            begin
                if (row_ok[dy] && col_ok[dx] && taps[CENTER + 1 - dy][CENTER + 1 - dx])
                begin
                    seed = 1'b1;
                end
            end
        end
    end

    // Count set cross pixels: four arms summed per radius, then the total
    always_comb
    begin
        for (int k = 1; k <= CROSS_RADIUS; k++)
        begin
            group_sum[k-1] = 3'(taps[CENTER][CENTER + k]) + 3'(taps[CENTER][CENTER - k]) +
                             3'(taps[CENTER + k][CENTER]) + 3'(taps[CENTER - k][CENTER]);
        end
        score = (SCORE_W'(group_sum[0]) + SCORE_W'(group_sum[1])) +
                (SCORE_W'(group_sum[2]) + SCORE_W'(group_sum[3]));
    end

    // Keep set pixels, fill a gap only with a seed and enough cross support
    assign center = taps[CENTER][CENTER];
    assign pixel  = center || (seed && (score >= threshold));

endmodule

// ===== design/binary_cross_gap_fill.sv =====
// Binary cross gap fill: takes a binary image of IMG_WIDTH x IMG_HEIGHT pixels in raster
// order and returns the cleaned image in the same order. A zero pixel is filled when a
// 3x3 neighbor at least five pixels inside every border is set and the radius-4 cross
// around it holds at least fill_threshold set pixels. The window is a chain of nine
// line cells, one image line each, shifting once per stored pixel or emitted result.
// One item is accepted per clock while in_ready is high; the first result appears after
// 4 lines plus 4 pixels of input, and each further pixel then yields one result. After
// the last pixel of a frame, send flush items (action = 1) to drain the remaining
// 4*IMG_WIDTH+4 results; the last one carries end_of_frame. Results pass through a
// two-entry output buffer, so in_ready drops whenever both entries are full.
module binary_cross_gap_fill (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bcgf_pkg::THRESH_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic                          pixel_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          pixel_out,
    output logic                          end_of_frame
);
    import bcgf_pkg::*;

    logic [THRESH_W-1:0] fill_threshold_reg;
    logic [THRESH_W-1:0] fill_threshold_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    win_pos_t            pos_reg;
    win_pos_t            pos_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             out_data_reg;
    result_t             out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    result_t             skid_data_reg;
    result_t             skid_data_next;

    logic                accept;
    logic                store;
    logic                drain;
    logic                emit;
    logic                last;
    logic                shift_en;
    logic                shift_in;
    logic                push;
    logic                pop;
    logic                fill_pixel;
    result_t             result;
    tap_grid_t           taps;
    logic [WIN_ROWS:0]   link;

    // Configuration register
    always_comb
    begin
        fill_threshold_next = fill_threshold_reg;
        if (cfg_write)
        begin
            fill_threshold_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_threshold_reg <= THRESH_W'(FILL_RESET);
        end
        else
        begin
            fill_threshold_reg <= fill_threshold_next;
        end
    end

    // Step control: store a pixel, emit a result, or both
    assign accept   = in_valid && in_ready;
    assign drain    = (count_reg == COUNT_W'(FRAME_PIXELS));
    assign store    = (action == ACT_PIXEL) && !drain;
    assign emit     = (store && (count_reg >= COUNT_W'(OUT_LAG))) || drain;
    assign last     = (pos_reg.row == ROW_W'(IMG_HEIGHT - 1)) &&
                      (pos_reg.col == COL_W'(IMG_WIDTH - 1));
    assign shift_en = accept && (store || emit);
    assign shift_in = store && pixel_in;
    assign push     = accept && emit;

    // Input count and output position
    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        if (push && last)
        begin
            count_next = '0;
            pos_next   = '0;
        end
        else
        begin
            if (accept && store)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            if (push)
            begin
                if (pos_reg.col == COL_W'(IMG_WIDTH - 1))
                begin
                    pos_next.col = '0;
                    pos_next.row = pos_reg.row + ROW_W'(1);
                end
                else
                begin
                    pos_next.col = pos_reg.col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    // Window: chain of line cells
    assign link[0] = shift_in;

    for (genvar r = 0; r < WIN_ROWS; r++)
    begin : g_cell
        bcgf_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .din      (link[r]),
            .taps     (taps[r]),
            .dout     (link[r+1])
        );
    end

    // Decision on the window as it stands after this shift
    bcgf_decide u_decide (
        .taps      (taps),
        .pos       (pos_reg),
        .threshold (fill_threshold_reg),
        .pixel     (fill_pixel)
    );

    assign result.pixel = fill_pixel;
    assign result.eof   = last;

    // Output register with skid entry
    assign pop      = out_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = result;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_data_next  = result;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = out_data_reg.pixel;
    assign end_of_frame = out_data_reg.eof;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(FRAME_PIXELS))
        else $error("input count beyond frame size");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg.row <= ROW_W'(IMG_HEIGHT - 1)) && (pos_reg.col <= COL_W'(IMG_WIDTH - 1)))
        else $error("output position outside frame");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (push && last) |=> (count_reg == '0) && (pos_reg == '0))
        else $error("counters not cleared after end of frame");

    a_last_needs_full_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (push && last) |-> drain)
        else $error("end of frame emitted before all pixels arrived");

endmodule
